>>> rtl/bds_pkg.sv
`timescale 1ns / 1ps
package bds_pkg;

   // Fixed geometry of one word.
   localparam int NCH        = 4;
   localparam int PIX_W      = 8;
   localparam int LANE_W     = PIX_W + 1;
   localparam int SRC_W      = 13;
   localparam int DST_W      = 12;
   localparam int CH_W       = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 3'd4;

   // Register values after reset.
   localparam logic [SRC_W-1:0] SRC_WIDTH_RST     = 13'd1;
   localparam logic [SRC_W-1:0] SRC_HEIGHT_RST    = 13'd1;
   localparam logic [DST_W-1:0] DST_WIDTH_RST     = 12'd1;
   localparam logic [DST_W-1:0] DST_HEIGHT_RST    = 12'd1;
   localparam logic [CH_W-1:0]  CHANNEL_COUNT_RST = 3'd4;

   typedef struct packed {
      logic [PIX_W-1:0] chan0;
      logic [PIX_W-1:0] chan1;
      logic [PIX_W-1:0] chan2;
      logic [PIX_W-1:0] chan3;
   } req_word_type;

   typedef struct packed {
      logic [PIX_W-1:0] out0;
      logic [PIX_W-1:0] out1;
      logic [PIX_W-1:0] out2;
      logic [PIX_W-1:0] out3;
      logic             frame_end;
   } rsp_word_type;

   // Word handed from the fetch stage to the reduce stage.
   typedef struct packed {
      logic [NCH-1:0][LANE_W-1:0] hsum;
      logic [NCH-1:0]             lane_on;
      logic                       use_mem;
      logic                       frame_end;
   } bds_stage_type;

endpackage

>>> rtl/bds_line_buf.sv
`timescale 1ns / 1ps
module bds_line_buf #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 2048,
   parameter int ADW   = 11
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic             rd_en,
   input  logic [ADW-1:0]   addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One access per cycle: a word either writes or reads its entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/bds_fetch.sv
`timescale 1ns / 1ps
module bds_fetch #(
   parameter int MAX_SRC_WIDTH = 4096,
   parameter int MAX_CHANNELS  = 4,
   parameter int ADW           = 11,
   parameter int MW            = 36
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [bds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bds_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  bds_pkg::req_word_type          req_word,
   input  logic                           s1_take,
   output logic                           s1_valid,
   output bds_pkg::bds_stage_type         s1_word,
   output logic                           mem_wr_en,
   output logic                           mem_rd_en,
   output logic [ADW-1:0]                 mem_addr,
   output logic [MW-1:0]                  mem_wdata
);

   import bds_pkg::*;

   localparam int SWW = $clog2(MAX_SRC_WIDTH + 1);
   localparam int AW  = ((SWW > SRC_W) ? SWW : SRC_W) + 1;
   localparam int CW  = $clog2(MAX_SRC_WIDTH);
   localparam int RW  = SRC_W + 1;

   logic [SRC_W-1:0] src_width_ff, src_height_ff;
   logic [DST_W-1:0] dst_width_ff, dst_height_ff;
   logic [CH_W-1:0]  ch_count_ff;

   logic [CW-1:0]    col_ff, col_in;
   logic [SRC_W-1:0] row_ff, row_in;
   logic [MAX_CHANNELS-1:0][PIX_W-1:0] pair_ff;

   logic          s1_valid_ff, s1_valid_in;
   bds_stage_type s1_word_ff, s1_word_in;

   logic [AW-1:0] sw_a, half_w, dstw_a, dw_a, col_a, xd_a;
   logic [RW-1:0] sh_r, half_h, dsth_r, dh_r, row_r, yd_r;
   logic [CH_W-1:0] ch_eff;
   logic [NCH-1:0][PIX_W-1:0]  px;
   logic [NCH-1:0][LANE_W-1:0] hsum;
   logic [NCH-1:0]             lane_on;
   logic accept, in_area, col_last, row_last, hdone, emit, pair_load, frame_end;

   // Configuration registers; a write to any index restarts the frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SRC_WIDTH_RST;
         src_height_ff <= SRC_HEIGHT_RST;
         dst_width_ff  <= DST_WIDTH_RST;
         dst_height_ff <= DST_HEIGHT_RST;
         ch_count_ff   <= CHANNEL_COUNT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:     src_width_ff  <= csr_wdata;
            CSR_SRC_HEIGHT:    src_height_ff <= csr_wdata;
            CSR_DST_WIDTH:     dst_width_ff  <= csr_wdata[DST_W-1:0];
            CSR_DST_HEIGHT:    dst_height_ff <= csr_wdata[DST_W-1:0];
            CSR_CHANNEL_COUNT: ch_count_ff   <= csr_wdata[CH_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective extents: zero acts as one, destination clamps to half the source.
   always_comb begin
      sw_a = (src_width_ff == '0) ? AW'(1) : AW'(src_width_ff);
      if (sw_a > AW'(MAX_SRC_WIDTH)) begin
         sw_a = AW'(MAX_SRC_WIDTH);
      end
      half_w = (sw_a + AW'(1)) >> 1;
      dstw_a = (dst_width_ff == '0) ? AW'(1) : AW'(dst_width_ff);
      dw_a   = (dstw_a > half_w) ? half_w : dstw_a;

      sh_r   = (src_height_ff == '0) ? RW'(1) : RW'(src_height_ff);
      half_h = (sh_r + RW'(1)) >> 1;
      dsth_r = (dst_height_ff == '0) ? RW'(1) : RW'(dst_height_ff);
      dh_r   = (dsth_r > half_h) ? half_h : dsth_r;

      ch_eff = (ch_count_ff > CH_W'(MAX_CHANNELS)) ? CH_W'(MAX_CHANNELS) : ch_count_ff;
   end

   assign px = {req_word.chan3, req_word.chan2, req_word.chan1, req_word.chan0};

   assign col_a    = AW'(col_ff);
   assign xd_a     = col_a >> 1;
   assign row_r    = RW'(row_ff);
   assign yd_r     = row_r >> 1;
   assign col_last = (col_a + AW'(1)) >= sw_a;
   assign row_last = (row_r + RW'(1)) >= sh_r;
   assign in_area  = (xd_a < dw_a) && (yd_r < dh_r);

   // A horizontal pair is complete on an odd column, or on the last column
   // where the even pixel counts twice.
   assign hdone     = in_area && (col_ff[0] || col_last);
   assign pair_load = in_area && !col_ff[0] && !col_last;
   assign emit      = hdone && (row_ff[0] || row_last);
   assign frame_end = (xd_a == dw_a - AW'(1)) && (yd_r == dh_r - RW'(1));

   genvar g;
   for (g = 0; g < NCH; g++) begin : g_lane
      if (g < MAX_CHANNELS) begin : g_on
         assign hsum[g] = col_ff[0] ? ({1'b0, pair_ff[g]} + {1'b0, px[g]})
                                    : {px[g], 1'b0};
         assign mem_wdata[g*LANE_W +: LANE_W] = hsum[g];
      end else begin : g_off
         assign hsum[g] = '0;
      end
      assign lane_on[g] = CH_W'(g) < ch_eff;
   end

   assign req_ready = !s1_valid_ff || s1_take;
   assign accept    = req_valid && req_ready;

   // Even rows park their pair sums, odd rows fetch them back.
   assign mem_wr_en = accept && hdone && !row_ff[0] && !row_last;
   assign mem_rd_en = accept && hdone && row_ff[0];
   assign mem_addr  = xd_a[ADW-1:0];

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_valid) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + SRC_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end

      s1_word_in.hsum      = hsum;
      s1_word_in.lane_on   = lane_on;
      s1_word_in.use_mem   = row_ff[0];
      s1_word_in.frame_end = frame_end;

      if (accept) begin
         s1_valid_in = emit;
      end else begin
         s1_valid_in = s1_valid_ff && !s1_take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pair_load) begin
         pair_ff <= px[MAX_CHANNELS-1:0];
      end
      if (accept && emit) begin
         s1_word_ff <= s1_word_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_word  = s1_word_ff;

endmodule

>>> rtl/bds_reduce.sv
`timescale 1ns / 1ps
module bds_reduce #(
   parameter int MAX_CHANNELS = 4,
   parameter int MW           = 36
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   s1_valid,
   input  bds_pkg::bds_stage_type s1_word,
   input  logic [MW-1:0]          rd_data,
   output logic                   s1_take,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bds_pkg::rsp_word_type  rsp_word
);

   import bds_pkg::*;

   logic [NCH-1:0][PIX_W-1:0] avg;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // Vertical sum of the two pair sums (or the single one doubled on the
   // last row), then round half up and divide by four.
   genvar g;
   for (g = 0; g < NCH; g++) begin : g_lane
      if (g < MAX_CHANNELS) begin : g_on
         logic [LANE_W:0] tot;
         logic [LANE_W:0] rnd;
         assign tot = s1_word.use_mem
                    ? ({1'b0, rd_data[g*LANE_W +: LANE_W]} + {1'b0, s1_word.hsum[g]})
                    : {s1_word.hsum[g], 1'b0};
         assign rnd = tot + (LANE_W+1)'(2);
         assign avg[g] = s1_word.lane_on[g] ? rnd[LANE_W:2] : '0;
      end else begin : g_off
         assign avg[g] = '0;
      end
   end

   assign s1_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in          = s1_take ? s1_valid : rsp_valid_ff;
      rsp_word_in.out0      = avg[0];
      rsp_word_in.out1      = avg[1];
      rsp_word_in.out2      = avg[2];
      rsp_word_in.out3      = avg[3];
      rsp_word_in.frame_end = s1_word.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take && s1_valid) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

>>> rtl/box_downsample_2x2.sv
`timescale 1ns / 1ps
// A word completing a 2x2 block passes the fetch register, then the reduce register. One
// source word per cycle while req_ready is high; the line buffer has a single port and
// each word makes at most one access to it, a write on even rows or a read on odd rows.
// Reset clears the configuration to its defaults, the frame position and all valid
// flags; the line buffer is never cleared, since every entry is written before it is read.
module box_downsample_2x2 #(
   parameter int MAX_SRC_WIDTH = 4096,
   parameter int MAX_CHANNELS  = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  bds_pkg::req_word_type          req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bds_pkg::rsp_word_type          rsp_word,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bds_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import bds_pkg::*;

   // The line buffer holds one horizontal pair sum per destination column,
   // nine bits for each channel that the build supports.
   localparam int LINE_DEPTH = (MAX_SRC_WIDTH + 1) / 2;
   localparam int ADW        = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int MW         = LANE_W * MAX_CHANNELS;

   logic          s1_valid, s1_take;
   bds_stage_type s1_word;
   logic          mem_wr_en, mem_rd_en;
   logic [ADW-1:0] mem_addr;
   logic [MW-1:0]  mem_wdata, mem_rdata;

   // Configuration writes are always taken; each one restarts the frame.
   assign csr_ready = 1'b1;

   // The fetch stage tracks the source position, pairs even and odd columns,
   // and either parks the pair sum of an even row or requests it back on the
   // odd row. Words that fall outside the used area are dropped here.
   bds_fetch #(
      .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
      .MAX_CHANNELS  (MAX_CHANNELS),
      .ADW           (ADW),
      .MW            (MW)
   ) u_fetch (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .s1_take   (s1_take),
      .s1_valid  (s1_valid),
      .s1_word   (s1_word),
      .mem_wr_en (mem_wr_en),
      .mem_rd_en (mem_rd_en),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata)
   );

   // A write always lands before the odd row reads the
   // same entry, so the buffer needs no forwarding path.
   bds_line_buf #(
      .WIDTH (MW),
      .DEPTH (LINE_DEPTH),
      .ADW   (ADW)
   ) u_line_buf (
      .clock (clock),
      .wr_en (mem_wr_en),
      .rd_en (mem_rd_en),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // The reduce stage adds the fetched pair sum, rounds, and owns the output
   // register that decouples the result side from the source side.
   bds_reduce #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .MW           (MW)
   ) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .s1_word   (s1_word),
      .rd_data   (mem_rdata),
      .s1_take   (s1_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // The single-port buffer never sees a write and a read together.
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("line buffer written and read in the same cycle");

   // Every buffer read feeds a word into the reduce stage that uses it.
   a_read_used: assert property (@(posedge clock) disable iff (reset)
      mem_rd_en |=> (s1_valid && s1_word.use_mem))
      else $error("line buffer read without a matching reduce word");

   // The source side stalls only when both stages are full and the result waits.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid && rsp_valid && !rsp_ready))
      else $error("source stalled without a full pipeline");

   // A stalled reduce word is still there in the next cycle.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && !s1_take) |=> (s1_valid && $stable(s1_word)))
      else $error("reduce word lost while stalled");

endmodule
